@@ rtl/hsort_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsort_pkg
// Shared types and helpers for the heap sorter: sequencer states, the data
// word and the signed compare used by the sift unit.
// ----------------------------------------------------------------------------
package hsort_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] hsort_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BUILD,
    S_GRAB,
    S_TEST,
    S_CMP,
    S_PUT,
    S_NEXT,
    S_EXT,
    S_SWAP_RD,
    S_SWAP_WR,
    S_OUT
  } hsort_state_e;

  // Signed greater-than on two data words.
  function automatic logic hsort_gt(input hsort_word_t a, input hsort_word_t b);
    return a > b;
  endfunction

endpackage

@@ rtl/heap_sorter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_sorter_core
// Collects signed words into an internal store, heap-sorts them in place and
// streams them out in ascending order.
// ----------------------------------------------------------------------------
// Usage: each request (start_i high while busy_o is low) stores one word.
// The request with last_in_i set also starts the sort, and busy_o stays
// high until the last result has been issued. The sort runs on one shared
// compare unit over a store with two read ports and one write port; each
// level of a sift-down is a test step, then a compare-and-move step.
// Results appear one per cycle, each for a single cycle with result_valid_o;
// the receiver cannot stall them. Words beyond CAPACITY are dropped and
// overflow_o is set on every result of that set. No clearing pass after
// reset is needed.
// ----------------------------------------------------------------------------
module heap_sorter_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  hsort_pkg::hsort_word_t      value_i,
  input  logic                        last_in_i,
  output logic                        result_valid_o,
  output hsort_pkg::hsort_word_t      sorted_value_o,
  output logic                        last_out_o,
  output logic                        overflow_o
);
  import hsort_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = AW + 2;

  hsort_word_t mem [CAPACITY];

  hsort_state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          extract_q, extract_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] size_q, size_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] k_q, k_d;
  hsort_word_t   cur_q, cur_d;

  hsort_word_t   rda_q, rdb_q;
  logic [AW-1:0] rd_addr_a, rd_addr_b;

  logic          we;
  logic [AW-1:0] wr_addr;
  hsort_word_t   wr_data;

  logic          res_valid_q, res_valid_d;
  logic          res_last_q, res_last_d;
  logic          res_ovf_q, res_ovf_d;

  logic          accept;
  logic          store_full;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] i_m1;
  logic [LW-1:0] left_w, right_w, size_x;
  logic          has_left, right_ok;
  logic [AW-1:0] big_addr;
  hsort_word_t   big_val;
  logic          move_down;
  logic          out_last;

  assign busy_o     = (state_q != S_IDLE);
  assign accept     = start_i && !busy_o;
  assign store_full = (count_q >= CW'(CAPACITY));
  assign count_inc  = store_full ? count_q : count_q + CW'(1);
  assign i_m1       = i_q - CW'(1);

  // Child addresses of the current hole.
  assign left_w   = {1'b0, pos_q, 1'b1};
  assign right_w  = left_w + LW'(1);
  assign size_x   = LW'(size_q);
  assign has_left = (left_w < size_x);
  assign right_ok = (right_w < size_x);

  // Shared compare unit: pick the larger child, then test it against the hole.
  always_comb begin
    if (right_ok && !hsort_gt(rda_q, rdb_q)) begin
      big_addr = right_w[AW-1:0];
      big_val  = rdb_q;
    end else begin
      big_addr = left_w[AW-1:0];
      big_val  = rda_q;
    end
  end
  assign move_down = hsort_gt(big_val, cur_q);
  assign out_last  = ((CW'(k_q) + CW'(1)) == count_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && last_in_i) begin
          state_d = ((count_inc >> 1) == '0) ? S_EXT : S_BUILD;
        end
      end
      S_BUILD:   state_d = S_GRAB;
      S_GRAB:    state_d = S_TEST;
      S_TEST:    state_d = has_left ? S_CMP : S_PUT;
      S_CMP:     state_d = move_down ? S_TEST : S_NEXT;
      S_PUT:     state_d = S_NEXT;
      S_NEXT: begin
        if (!extract_q && (i_q > CW'(1))) begin
          state_d = S_BUILD;
        end else begin
          state_d = S_EXT;
        end
      end
      S_EXT:     state_d = (i_q > CW'(1)) ? S_SWAP_RD : S_OUT;
      S_SWAP_RD: state_d = S_SWAP_WR;
      S_SWAP_WR: state_d = S_TEST;
      S_OUT:     state_d = out_last ? S_IDLE : S_OUT;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    extract_d   = extract_q;
    i_d         = i_q;
    size_d      = size_q;
    pos_d       = pos_q;
    k_d         = k_q;
    cur_d       = cur_q;
    rd_addr_a   = pos_q;
    rd_addr_b   = pos_q;
    we          = 1'b0;
    wr_addr     = pos_q;
    wr_data     = cur_q;
    res_valid_d = 1'b0;
    res_last_d  = res_last_q;
    res_ovf_d   = res_ovf_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!store_full) begin
            we      = 1'b1;
            wr_addr = count_q[AW-1:0];
            wr_data = value_i;
          end else begin
            ovf_d = 1'b1;
          end
          count_d = count_inc;
          if (last_in_i) begin
            k_d = '0;
            if ((count_inc >> 1) == '0) begin
              extract_d = 1'b1;
              i_d       = count_inc;
            end else begin
              extract_d = 1'b0;
              i_d       = count_inc >> 1;
            end
          end
        end
      end
      S_BUILD: begin
        // Open a hole at i-1 over the whole set.
        rd_addr_a = i_m1[AW-1:0];
        pos_d     = i_m1[AW-1:0];
        size_d    = count_q;
      end
      S_GRAB: begin
        cur_d = rda_q;
      end
      S_TEST: begin
        rd_addr_a = left_w[AW-1:0];
        rd_addr_b = right_ok ? right_w[AW-1:0] : left_w[AW-1:0];
      end
      S_CMP: begin
        we = 1'b1;
        if (move_down) begin
          // Pull the larger child up into the hole and descend.
          wr_data = big_val;
          pos_d   = big_addr;
        end
      end
      S_PUT: begin
        we = 1'b1;
      end
      S_NEXT: begin
        if (!extract_q && (i_q > CW'(1))) begin
          i_d = i_m1;
        end else if (!extract_q) begin
          extract_d = 1'b1;
          i_d       = count_q;
        end else begin
          i_d = i_m1;
        end
      end
      S_EXT: begin
        k_d = '0;
      end
      S_SWAP_RD: begin
        rd_addr_a = '0;
        rd_addr_b = i_m1[AW-1:0];
      end
      S_SWAP_WR: begin
        // Move the root to the end and sift the old end from the top.
        we      = 1'b1;
        wr_addr = i_m1[AW-1:0];
        wr_data = rda_q;
        cur_d   = rdb_q;
        pos_d   = '0;
        size_d  = i_m1;
      end
      S_OUT: begin
        rd_addr_a   = k_q;
        k_d         = k_q + AW'(1);
        res_valid_d = 1'b1;
        res_last_d  = out_last;
        res_ovf_d   = ovf_q;
        if (out_last) begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      extract_q   <= 1'b0;
      i_q         <= '0;
      size_q      <= '0;
      pos_q       <= '0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      extract_q   <= extract_d;
      i_q         <= i_d;
      size_q      <= size_d;
      pos_q       <= pos_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    res_last_q <= res_last_d;
    res_ovf_q  <= res_ovf_d;
  end

  // Element store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rda_q <= mem[rd_addr_a];
    rdb_q <= mem[rd_addr_b];
  end

  assign result_valid_o = res_valid_q;
  assign sorted_value_o = rda_q;
  assign last_out_o     = res_last_q;
  assign overflow_o     = res_ovf_q;

  // Leaving the busy phase only happens with the final result on the ports.
  a_fell_busy_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (result_valid_o && last_out_o))
    else $error("busy dropped without final result");

  // Every result before the final one is issued while the block is still busy.
  a_mid_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_out_o) |-> busy_o)
    else $error("intermediate result while idle");

  // The fill count never passes the store size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count beyond capacity");

  // A request into a full store is remembered as overflow.
  a_overflow_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && store_full) |=> ovf_q)
    else $error("dropped request not flagged");

  // The hole under test always lies inside the current heap.
  a_hole_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TEST) |-> (LW'(pos_q) < size_x))
    else $error("sift position outside heap");

endmodule
